@@ design/psas_pkg.sv @@
// Shared types and constants for the pan swing and angle stop controller.
`timescale 1ns / 1ps

package psas_pkg;

	// Event codes carried on the input tuser
	localparam logic [2:0] CMD_TICK  = 3'd0;
	localparam logic [2:0] CMD_SWING = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_REL   = 3'd3;
	localparam logic [2:0] CMD_AZ    = 3'd4;

	// Configuration register indexes
	localparam logic [1:0] REG_SPEED        = 2'd0;
	localparam logic [1:0] REG_MOVE_TIME    = 2'd1;
	localparam logic [1:0] REG_PAUSE_TIME   = 2'd2;
	localparam logic [1:0] REG_LIGHT_TOGGLE = 2'd3;

	// Light action codes
	localparam logic [1:0] LIGHT_NONE = 2'd0;
	localparam logic [1:0] LIGHT_ON   = 2'd1;
	localparam logic [1:0] LIGHT_OFF  = 2'd2;

	// Angles (FULL_TURN, TARGET_MAX) in tenths of a degree; minimum move and pause times in ticks; speed limit
	localparam int FULL_TURN  = 3600;
	localparam int MOVE_MIN   = 100;
	localparam int PAUSE_MIN  = 50;
	localparam int SPEED_MAX  = 100;
	localparam int TARGET_MAX = 4095;

	// Register reset values
	localparam logic signed [7:0] SPEED_RST      = 8'sd50;
	localparam logic [15:0]       MOVE_TIME_RST  = 16'd1800;
	localparam logic [15:0]       PAUSE_TIME_RST = 16'd450;
	localparam logic              LIGHT_TOG_RST  = 1'b1;
	localparam logic [11:0]       TARGET_RST     = 12'd150;

	typedef struct packed {
		logic signed [7:0] speed;
		logic [15:0]       move_time;
		logic [15:0]       pause_time;
		logic              light_toggle;
	} cfg_t;

	typedef struct packed {
		logic              relative_active;
		logic              swing_active;
		logic [1:0]        light_action;
		logic signed [7:0] pan_command;
	} result_t;

endpackage

@@ design/pan_swing_and_angle_stop.sv @@
// Top level of the pan swing and angle stop controller.
// An accepted item waits in the input register; any result it makes goes to the result register.
// Throughput: one item per cycle unless the output stalls; the input register and the result
// register are the only stages, and the controller state updates in the same cycle an item leaves stage 1.
// Reset (arst_n low, asynchronous): swing and relative pan idle, timer idle,
// registers back to speed 50, move_time 1800, pause_time 450, light_toggle 1.
`timescale 1ns / 1ps

module pan_swing_and_angle_stop import psas_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // pan_delta[12:0], azimuth[24:13], zero pad
	input  logic [2:0]  s_axis_tuser,   // command[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // pan_command[7:0], light_action[9:8],
	                                    // swing_active[10], relative_active[11], zero pad
);

	cfg_t cfg_q;

	logic               valid_s1;
	logic [2:0]         cmd_s1;
	logic signed [12:0] delta_s1;
	logic [11:0]        az_s1;

	logic    adv;
	logic    fire;
	logic    res_valid;
	result_t res;
	logic    out_valid_q;
	result_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed        <= SPEED_RST;
			cfg_q.move_time    <= MOVE_TIME_RST;
			cfg_q.pause_time   <= PAUSE_TIME_RST;
			cfg_q.light_toggle <= LIGHT_TOG_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SPEED:        cfg_q.speed        <= $signed(cfg_data[7:0]);
				REG_MOVE_TIME:    cfg_q.move_time    <= cfg_data;
				REG_PAUSE_TIME:   cfg_q.pause_time   <= cfg_data;
				REG_LIGHT_TOGGLE: cfg_q.light_toggle <= cfg_data[0];
			endcase
		end
	end

	assign adv           = !out_valid_q || m_axis_tready;
	assign fire          = valid_s1 && adv;
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_s1   <= s_axis_tuser;
			delta_s1 <= $signed(s_axis_tdata[12:0]);
			az_s1    <= s_axis_tdata[24:13];
		end
	end

	psas_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.cmd       (cmd_s1),
		.pan_delta (delta_s1),
		.azimuth   (az_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid)
			out_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, out_q};

	// a held stage-1 item is never dropped while the output stalls
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1)
		else $error("stage 1 item lost during stall");

	a_pan_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(m_axis_tdata[7:0]) >= -8'sd100 &&
		                   $signed(m_axis_tdata[7:0]) <= 8'sd100))
		else $error("pan command out of range");

	a_light_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[9:8] != LIGHT_NONE |->
		(m_axis_tdata[9:8] == LIGHT_ON || m_axis_tdata[9:8] == LIGHT_OFF) &&
		m_axis_tdata[10])
		else $error("light command without running swing");

endmodule

@@ design/psas_core.sv @@
// Controller state and per-event next-state and result logic.
`timescale 1ns / 1ps

module psas_core import psas_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [2:0]          cmd,
	input  logic signed [12:0]  pan_delta,
	input  logic [11:0]         azimuth,
	input  cfg_t                cfg,
	output logic                res_valid,
	output result_t             res
);

	typedef enum logic [1:0] {
		PH_RIGHT,
		PH_PAUSE_R,
		PH_LEFT,
		PH_PAUSE_L
	} phase_t;

	localparam logic signed [13:0] TURN_S = 14'(FULL_TURN);

	logic        swing_q, n_swing;
	phase_t      phase_q, n_phase, ph_cur;
	logic [15:0] cnt_q, n_cnt;
	logic        rel_q, n_rel;
	logic        known_q, n_known;
	logic [11:0] start_q, n_start;
	logic [11:0] target_q, n_target;
	logic        neg_q, n_neg;

	logic [7:0]        spd_abs;
	logic [6:0]        spd_mag;
	logic signed [7:0] spd_pos, spd_neg;
	logic [15:0]       eff_move, eff_pause;
	logic [12:0]       dabs;
	logic [11:0]       tgt;
	logic signed [13:0] diff, wrapped, travel;
	logic              done;
	logic              adv_sw;
	logic              emit;

	assign spd_abs   = cfg.speed[7] ? 8'(-cfg.speed) : 8'(cfg.speed);
	assign spd_mag   = (spd_abs > 8'(SPEED_MAX)) ? 7'(SPEED_MAX) : spd_abs[6:0];
	assign spd_pos   = $signed({1'b0, spd_mag});
	assign spd_neg   = -spd_pos;
	assign eff_move  = (cfg.move_time < 16'(MOVE_MIN)) ? 16'(MOVE_MIN) : cfg.move_time;
	assign eff_pause = (cfg.pause_time < 16'(PAUSE_MIN)) ? 16'(PAUSE_MIN) : cfg.pause_time;

	assign dabs = pan_delta[12] ? 13'(-pan_delta) : 13'(pan_delta);
	assign tgt  = (dabs == 13'd0) ? 12'd1 :
	              (dabs > 13'(TARGET_MAX)) ? 12'(TARGET_MAX) : dabs[11:0];

	// travel in the commanded direction, one wrap each way
	assign diff    = neg_q ? ($signed({2'b00, start_q}) - $signed({2'b00, azimuth}))
	                       : ($signed({2'b00, azimuth}) - $signed({2'b00, start_q}));
	assign wrapped = (diff < 14'sd0) ? diff + TURN_S : diff;
	assign travel  = (wrapped >= TURN_S) ? wrapped - TURN_S : wrapped;
	assign done    = travel >= $signed({2'b00, target_q});

	always_comb begin
		n_swing  = swing_q;
		n_phase  = phase_q;
		n_cnt    = cnt_q;
		n_rel    = rel_q;
		n_known  = known_q;
		n_start  = start_q;
		n_target = target_q;
		n_neg    = neg_q;
		ph_cur   = phase_q;
		adv_sw   = 1'b0;
		emit     = 1'b0;
		res.pan_command  = 8'sd0;
		res.light_action = LIGHT_NONE;
		unique case (cmd)
			CMD_TICK: begin
				if (swing_q && cnt_q != 16'd0) begin
					n_cnt = cnt_q - 16'd1;
					if (cnt_q == 16'd1)
						adv_sw = 1'b1;
				end
			end
			CMD_SWING: begin
				if (!swing_q) begin
					n_swing = 1'b1;
					ph_cur  = PH_RIGHT;
					adv_sw  = 1'b1;
				end
			end
			CMD_STOP: begin
				if (swing_q || rel_q) begin
					n_swing = 1'b0;
					n_cnt   = 16'd0;
					n_rel   = 1'b0;
					n_known = 1'b0;
					emit    = 1'b1;
				end
			end
			CMD_REL: begin
				n_target = tgt;
				n_neg    = pan_delta[12];
				n_rel    = 1'b1;
				n_known  = 1'b0;
				emit     = 1'b1;
				res.pan_command = pan_delta[12] ? spd_neg : spd_pos;
			end
			CMD_AZ: begin
				if (rel_q) begin
					if (!known_q) begin
						n_start = azimuth;
						n_known = 1'b1;
					end else if (done) begin
						n_rel = 1'b0;
						emit  = 1'b1;
					end
				end
			end
			default: ;
		endcase
		if (adv_sw) begin
			emit = 1'b1;
			unique case (ph_cur)
				PH_RIGHT: begin
					res.light_action = cfg.light_toggle ? LIGHT_ON : LIGHT_NONE;
					res.pan_command  = spd_pos;
					n_phase = PH_PAUSE_R;
					n_cnt   = eff_move;
				end
				PH_PAUSE_R: begin
					n_phase = PH_LEFT;
					n_cnt   = eff_pause;
				end
				PH_LEFT: begin
					res.light_action = cfg.light_toggle ? LIGHT_OFF : LIGHT_NONE;
					res.pan_command  = spd_neg;
					n_phase = PH_PAUSE_L;
					n_cnt   = eff_move;
				end
				PH_PAUSE_L: begin
					n_phase = PH_RIGHT;
					n_cnt   = eff_pause;
				end
			endcase
		end
		res.swing_active    = n_swing;
		res.relative_active = n_rel;
	end

	assign res_valid = fire && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swing_q  <= 1'b0;
			phase_q  <= PH_RIGHT;
			cnt_q    <= 16'd0;
			rel_q    <= 1'b0;
			known_q  <= 1'b0;
			start_q  <= 12'd0;
			target_q <= TARGET_RST;
			neg_q    <= 1'b0;
		end else if (fire) begin
			swing_q  <= n_swing;
			phase_q  <= n_phase;
			cnt_q    <= n_cnt;
			rel_q    <= n_rel;
			known_q  <= n_known;
			start_q  <= n_start;
			target_q <= n_target;
			neg_q    <= n_neg;
		end
	end

endmodule

@@ test/psas_checker.sv @@
// Checker for the pan swing and angle stop controller: predicts every result and compares it.
`timescale 1ns / 1ps

module psas_checker import psas_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] in_data,    // pan_delta[12:0], azimuth[24:13], zero pad
	input  logic [2:0]  in_cmd,     // command[2:0]
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] out_data,   // pan_command[7:0], light_action[9:8],
	                                // swing_active[10], relative_active[11], zero pad
	output int          pending,
	output int          errors
);

	typedef enum logic [1:0] {PH_RIGHT, PH_HOLD_R, PH_LEFT, PH_HOLD_L} phase_e;

	logic signed [7:0] speed_set;
	logic [15:0]       move_set;
	logic [15:0]       pause_set;
	logic              light_set;

	logic        swinging;
	phase_e      phase;
	logic [15:0] countdown;
	logic        rel_on;
	logic        rel_latched;
	logic [11:0] rel_origin;
	logic [11:0] rel_goal;
	logic        rel_left;

	result_t pan_results_q[$];
	int      fail_count;

	function automatic logic signed [7:0] speed_mag();
		int m;
		m = (speed_set < 0) ? -int'(speed_set) : int'(speed_set);
		return (m > SPEED_MAX) ? 8'(SPEED_MAX) : 8'(m);
	endfunction

	function automatic logic [15:0] at_least(logic [15:0] v, int lo);
		return (v < lo) ? 16'(lo) : v;
	endfunction

	function automatic result_t make_result(logic signed [7:0] pan, logic [1:0] light);
		result_t r;
		r.pan_command     = pan;
		r.light_action    = light;
		r.swing_active    = swinging;
		r.relative_active = rel_on;
		return r;
	endfunction

	function automatic result_t advance_swing();
		logic signed [7:0] pan;
		logic [1:0]        light;
		pan   = '0;
		light = LIGHT_NONE;
		case (phase)
			PH_RIGHT: begin
				light     = light_set ? LIGHT_ON : LIGHT_NONE;
				pan       = speed_mag();
				phase     = PH_HOLD_R;
				countdown = at_least(move_set, MOVE_MIN);
			end
			PH_HOLD_R: begin
				phase     = PH_LEFT;
				countdown = at_least(pause_set, PAUSE_MIN);
			end
			PH_LEFT: begin
				light     = light_set ? LIGHT_OFF : LIGHT_NONE;
				pan       = -speed_mag();
				phase     = PH_HOLD_L;
				countdown = at_least(move_set, MOVE_MIN);
			end
			default: begin
				phase     = PH_RIGHT;
				countdown = at_least(pause_set, PAUSE_MIN);
			end
		endcase
		return make_result(pan, light);
	endfunction

	// Updates the controller state for one event; returns 1 when a pan command goes out.
	function automatic bit apply_event(logic [2:0] cmd, logic signed [12:0] delta,
		logic [11:0] az, output result_t r);
		int mag;
		int travel;
		r = '0;
		case (cmd)
			CMD_TICK: begin
				if (!swinging || countdown == 0)
					return 0;
				countdown--;
				if (countdown != 0)
					return 0;
				r = advance_swing();
				return 1;
			end
			CMD_SWING: begin
				if (swinging)
					return 0;
				swinging = 1'b1;
				phase    = PH_RIGHT;
				r = advance_swing();
				return 1;
			end
			CMD_STOP: begin
				if (!swinging && !rel_on)
					return 0;
				swinging    = 1'b0;
				countdown   = '0;
				rel_on      = 1'b0;
				rel_latched = 1'b0;
				r = make_result('0, LIGHT_NONE);
				return 1;
			end
			CMD_REL: begin
				mag = (delta < 0) ? -int'(delta) : int'(delta);
				if (mag < 1)
					mag = 1;
				if (mag > TARGET_MAX)
					mag = TARGET_MAX;
				rel_goal    = 12'(mag);
				rel_left    = (delta < 0);
				rel_on      = 1'b1;
				rel_latched = 1'b0;
				r = make_result(rel_left ? -speed_mag() : speed_mag(), LIGHT_NONE);
				return 1;
			end
			CMD_AZ: begin
				if (!rel_on)
					return 0;
				if (!rel_latched) begin
					rel_origin  = az;
					rel_latched = 1'b1;
					return 0;
				end
				travel = rel_left ? int'(rel_origin) - int'(az) : int'(az) - int'(rel_origin);
				if (travel < 0)
					travel += FULL_TURN;
				travel = travel % FULL_TURN;
				if (travel >= int'(rel_goal)) begin
					rel_on = 1'b0;
					r = make_result('0, LIGHT_NONE);
					return 1;
				end
				return 0;
			end
			default: return 0;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		if (!arst_n) begin
			speed_set   = SPEED_RST;
			move_set    = MOVE_TIME_RST;
			pause_set   = PAUSE_TIME_RST;
			light_set   = LIGHT_TOG_RST;
			swinging    = 1'b0;
			phase       = PH_RIGHT;
			countdown   = '0;
			rel_on      = 1'b0;
			rel_latched = 1'b0;
			rel_origin  = '0;
			rel_goal    = TARGET_RST;
			rel_left    = 1'b0;
			fail_count  = 0;
			pan_results_q.delete();
			pending <= 0;
			errors  <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SPEED:      speed_set = cfg_data[7:0];
					REG_MOVE_TIME:  move_set  = cfg_data;
					REG_PAUSE_TIME: pause_set = cfg_data;
					default:        light_set = cfg_data[0];
				endcase
			end
			if (out_valid && out_ready) begin
				got = result_t'(out_data[11:0]);
				if (pan_results_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("[psas_chk] %0t unexpected item: pan %0d light %0d swing %0b rel %0b",
							$time, got.pan_command, got.light_action, got.swing_active,
							got.relative_active);
				end else begin
					want = pan_results_q.pop_front();
					if (got.pan_command !== want.pan_command ||
						got.light_action !== want.light_action ||
						got.swing_active !== want.swing_active ||
						got.relative_active !== want.relative_active) begin
						fail_count++;
						if (fail_count <= 10) begin
							$write("[psas_chk] %0t mismatch: expected pan %0d light %0d swing %0b rel %0b",
								$time, want.pan_command, want.light_action, want.swing_active,
								want.relative_active);
							$display(", got pan %0d light %0d swing %0b rel %0b",
								got.pan_command, got.light_action, got.swing_active,
								got.relative_active);
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				if (apply_event(in_cmd, in_data[12:0], in_data[24:13], want))
					pan_results_q.insert(pan_results_q.size(), want);
			end
			pending <= pan_results_q.size();
			errors  <= fail_count;
		end
	end

endmodule

@@ test/tb_pan_swing_and_angle_stop.sv @@
// Testbench top for the pan swing and angle stop controller: clock, reset, stimulus, verdict.
`timescale 1ns / 1ps

module tb_pan_swing_and_angle_stop;
	import psas_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // pan_delta[12:0], azimuth[24:13], zero pad
	logic [2:0]  s_axis_tuser;   // command[2:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;   // pan_command[7:0], light_action[9:8],
	                             // swing_active[10], relative_active[11], zero pad

	int send_idle_pct = 12;
	int rcv_stall_pct = 79;
	int cycles = 0;
	int pending;
	int errors;

	always #4 clk = ~clk;

	pan_swing_and_angle_stop dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	psas_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.in_cmd    (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.pending   (pending),
		.errors    (errors)
	);

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[pan_swing_and_angle_stop] ERROR");
			$finish;
		end
	end

	task automatic send_item(input logic [2:0] cmd, input logic [12:0] delta,
		input logic [11:0] az);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {7'd0, az, delta};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic set_config(input logic signed [7:0] spd, input logic [15:0] mv,
		input logic [15:0] ps, input logic lt);
		cfg_we    <= 1'b1;
		cfg_index <= REG_SPEED;
		cfg_data  <= {8'($urandom), spd};
		@(posedge clk);
		cfg_index <= REG_MOVE_TIME;
		cfg_data  <= mv;
		@(posedge clk);
		cfg_index <= REG_PAUSE_TIME;
		cfg_data  <= ps;
		@(posedge clk);
		cfg_index <= REG_LIGHT_TOGGLE;
		cfg_data  <= {15'($urandom), lt};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// hold off until every pan command is back, then idle past the pipeline depth
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input int n_items);
		int               sent;
		int               pick;
		int               burst;
		int               goal;
		int               moved;
		int               steps;
		int               step;
		int               p;
		logic [2:0]       cmd;
		logic signed [12:0] delta;
		logic [11:0]      pos;
		bit               left;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				burst = $urandom_range(1, 60);
				repeat (burst) send_item(CMD_TICK, 13'($urandom), 12'($urandom));
				sent += burst;
			end else if (pick < 60) begin
				send_item(CMD_SWING, 13'($urandom), 12'($urandom));
				sent++;
			end else if (pick < 78) begin
				// relative pan: latch, then sweep toward the target with wrap
				if ($urandom_range(0, 4) == 0) begin
					delta = 13'($urandom);
				end else begin
					delta = 13'($urandom_range(0, 600));
					if ($urandom_range(0, 1))
						delta = -delta;
				end
				left = (delta < 0);
				goal = left ? -int'(delta) : int'(delta);
				if (goal < 1)
					goal = 1;
				pos = 12'($urandom_range(0, FULL_TURN - 1));
				send_item(CMD_REL, delta, 12'($urandom));
				send_item(CMD_AZ, 13'($urandom), pos);
				sent += 2;
				moved = 0;
				steps = 0;
				while (moved < goal && steps < 12) begin
					step  = $urandom_range(0, goal / 3 + 8);
					moved += step;
					p = int'(pos) + (left ? -step : step);
					if (p < 0)
						p += FULL_TURN;
					if (p >= FULL_TURN)
						p -= FULL_TURN;
					if ($urandom_range(0, 15) == 0)
						send_item(CMD_AZ, 13'($urandom), 12'($urandom_range(FULL_TURN, 4095)));
					if ($urandom_range(0, 3) == 0)
						send_item(CMD_TICK, 13'($urandom), 12'($urandom));
					pos = 12'(p);
					send_item(CMD_AZ, 13'($urandom), pos);
					steps++;
					sent++;
				end
			end else if (pick < 82) begin
				send_item(CMD_STOP, 13'($urandom), 12'($urandom));
				sent++;
			end else if (pick < 92) begin
				cmd = 3'($urandom);
				send_item(cmd, 13'($urandom), 12'($urandom));
				if (cmd <= CMD_AZ)
					sent++;
			end else begin
				send_item(CMD_AZ, 13'($urandom), 12'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= REG_SPEED;
		cfg_data      <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= CMD_TICK;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ignored events: idle tick, idle stop, report with no pan, unknown codes
		send_item(CMD_TICK, 13'd0, 12'd0);
		send_item(CMD_STOP, 13'd0, 12'd0);
		send_item(CMD_AZ, 13'd0, 12'hFFF);
		for (int c = CMD_AZ + 1; c < 8; c++)
			send_item(3'(c), 13'h1FFF, 12'hFFF);
		// zero delta counts as a one-tenth right pan, finished across the wrap
		send_item(CMD_REL, 13'd0, 12'd0);
		send_item(CMD_AZ, 13'd0, 12'(FULL_TURN - 1));
		send_item(CMD_AZ, 13'd0, 12'd0);
		// most negative delta saturates; out of range report never completes
		send_item(CMD_REL, 13'h1000, 12'd0);
		send_item(CMD_AZ, 13'd0, 12'd100);
		send_item(CMD_AZ, 13'd0, 12'hFFF);
		send_item(CMD_AZ, 13'd0, 12'd200);
		send_item(CMD_STOP, 13'd0, 12'd0);
		// largest positive target is beyond a full turn
		send_item(CMD_REL, 13'h0FFF, 12'd0);
		send_item(CMD_AZ, 13'd0, 12'd0);
		send_item(CMD_AZ, 13'd0, 12'(FULL_TURN - 1));
		send_item(CMD_STOP, 13'd0, 12'd0);
		// swing start, repeated start, relative pan during swing, then ticks and a stop
		send_item(CMD_SWING, 13'd0, 12'd0);
		send_item(CMD_SWING, 13'd0, 12'd0);
		send_item(CMD_REL, 13'h1FFF, 12'd0);
		send_item(CMD_TICK, 13'd0, 12'd0);
		send_item(CMD_STOP, 13'd0, 12'd0);
		send_item(CMD_TICK, 13'd0, 12'd0);
		drain();

		set_config(-8'sd128, 16'd0, 16'd0, 1'b1);
		run_phase(140);
		drain();
		run_phase(140);
		drain();
		set_config(8'sd127, 16'd100, 16'd50, 1'b0);
		run_phase(280);
		drain();

		send_idle_pct <= 79;
		rcv_stall_pct <= 12;
		set_config(8'sd0, 16'($urandom_range(101, 130)), 16'($urandom_range(50, 70)), 1'b1);
		run_phase(280);
		drain();
		set_config(-8'sd100, 16'hFFFF, 16'hFFFF, 1'b0);
		run_phase(200);
		drain();

		send_idle_pct <= 0;
		rcv_stall_pct <= 0;
		set_config(8'sd100, 16'($urandom_range(0, 150)), 16'($urandom_range(0, 80)),
			1'($urandom));
		run_phase(280);
		drain();
		set_config(8'($urandom), 16'($urandom_range(0, 140)), 16'($urandom_range(0, 70)),
			1'($urandom));
		run_phase(280);
		drain();
		repeat (8) @(posedge clk);

		if (errors == 0) begin
			$display("[pan_swing_and_angle_stop] OK");
		end else begin
			$display("[pan_swing_and_angle_stop] ERROR");
		end
		$finish;
	end

endmodule

@@ pan_swing_and_angle_stop.f @@
design/psas_pkg.sv
design/psas_core.sv
design/pan_swing_and_angle_stop.sv
test/psas_checker.sv
test/tb_pan_swing_and_angle_stop.sv
